>>> sv/lmdd_pkg.sv
package lmdd_pkg;

    localparam int DELAY_DEPTH      = 4096;
    localparam int SAMPLE_BITS      = 24;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int ADDR_BITS     = $clog2(DELAY_DEPTH);
    localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int FRAC_BITS     = 8;
    localparam int PHASE_BITS    = 24;
    localparam int Q15_BITS      = 15;
    localparam int Q15_ONE       = 32768;
    localparam int SINE_BITS     = 15;

    // configuration register indexes
    localparam logic [2:0] REG_PHASE_INC  = 3'd0;
    localparam logic [2:0] REG_PHASE_OFF  = 3'd1;
    localparam logic [2:0] REG_DETUNE     = 3'd2;
    localparam logic [2:0] REG_WET_MIX    = 3'd3;
    localparam logic [2:0] REG_CENTER     = 3'd4;
    localparam logic [2:0] REG_MAX_DEPTH  = 3'd5;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // taylor series divisors (2k)(2k+1) for k = 1..7
    localparam longint unsigned SERIES_DIV [1:7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [ADDR_BITS-1:0]          t_addr;
    typedef logic [SINE_BITS-1:0]          t_sine_tbl [0:SINE_TABLE_DEPTH];

    // quarter-wave sine, unsigned q0.15 with scale 32767, evaluated at elaboration
    function automatic t_sine_tbl f_sine_table();
        t_sine_tbl          tbl;
        longint unsigned    x;
        longint unsigned    term;
        longint unsigned    r;
        longint             sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = HALF_PI_Q30 * longint'(i) / SINE_TABLE_DEPTH;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / SERIES_DIV[k];
                if (k[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (r > 64'd32767) begin
                r = 64'd32767;
            end
            tbl[i] = r[SINE_BITS-1:0];
        end
        return tbl;
    endfunction

    localparam t_sine_tbl SINE_TBL = f_sine_table();

endpackage

>>> sv/lmdd_delay_mem.sv
module lmdd_delay_mem (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  lmdd_pkg::t_addr       i_wr_addr,
    input  lmdd_pkg::t_sample     i_wr_data,
    input  logic                  i_rd_en,
    input  lmdd_pkg::t_addr       i_rd_addr,
    output lmdd_pkg::t_sample     o_rd_data
);
    import lmdd_pkg::*;

    t_sample              mem [DELAY_DEPTH];
    t_sample              r_rd_raw;
    logic                 r_rd_ok;
    logic [ADDR_BITS:0]   r_fill;

    // writes go strictly in address order from zero, so a fill count
    // tells which entries are still unwritten; those read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_wr_en && (r_fill != (ADDR_BITS+1)'(DELAY_DEPTH))) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_raw <= mem[i_rd_addr];
            r_rd_ok  <= ({1'b0, i_rd_addr} < r_fill);
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_raw : '0;

endmodule

>>> sv/lfo_modulated_delay_doubler.sv
// modulated delay doubler: chorus-style delay line with a sine lfo
//
// input channel: i_in_valid / o_in_stall with i_sample_in; a request is
// taken when valid is high and stall is low. output channel: o_out_valid /
// i_out_stall with o_sample_out, one result per request, in order.
// configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high. index 0 phase increment, 1 phase offset,
// 2 detune, 3 wet mix, 4 center delay, 5 max depth; other indexes ignored.
//
// each request runs through a 10-step sequencer: lfo table lookup, two
// swing multiplies, delay clamp, two reads of the delay memory (one read
// port, registered), two interpolation and two mix multiplies.
// the result goes to the output register from the last step, after which
// the sequencer returns to idle; a new request is taken only in idle. the
// output register lets the next request enter while a result is held; if
// the receiver stalls, the sequencer waits in its last step until the
// output register frees up.
// reset clears the lfo phase, write pointer, state, output valid and delay
// memory fill count; unwritten entries read as zero, no clearing pass.
module lfo_modulated_delay_doubler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [lmdd_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [lmdd_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [2:0]                           i_cfg_index,
    input  logic [23:0]                          i_cfg_data
);
    import lmdd_pkg::*;

    localparam int CENTER_BITS = 20;
    localparam int DEPTH_BITS  = 20;
    localparam int MIXW_BITS   = 16;
    localparam int PROD1_BITS  = SINE_BITS + DEPTH_BITS;
    localparam int PROD2_BITS  = PROD1_BITS + MIXW_BITS;
    localparam int MAG_BITS    = PROD2_BITS - 30;
    localparam int DLY_BITS    = ADDR_BITS + FRAC_BITS;
    localparam int DSUM_BITS   = ((MAG_BITS > CENTER_BITS) ? MAG_BITS : CENTER_BITS) + 2;
    localparam int WA_BITS     = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int MA_BITS     = SAMPLE_BITS + Q15_BITS + 3;
    localparam int RES_BITS    = MA_BITS - Q15_BITS;
    localparam longint MAX_DELAY = longint'(DELAY_DEPTH - 2) * (longint'(1) << FRAC_BITS);

    localparam logic signed [RES_BITS-1:0] RES_MAX =
        RES_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RES_BITS-1:0] RES_MIN = -RES_MAX - RES_BITS'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_SINE, S_MUL1, S_MUL2, S_DELAY,
        S_RD0, S_RD1, S_WET, S_MIX0, S_MIX1, S_OUT
    } t_state;

    t_state                     r_state;

    // configuration
    logic [PHASE_BITS-1:0]      r_phase_inc;
    logic [PHASE_BITS-1:0]      r_phase_off;
    logic [MIXW_BITS-1:0]       r_detune;
    logic [MIXW_BITS-1:0]       r_wet_mix;
    logic [CENTER_BITS-1:0]     r_center;
    logic [DEPTH_BITS-1:0]      r_max_depth;

    // per-sample state
    logic [PHASE_BITS-1:0]      r_lfo_phase;
    t_addr                      r_wp;

    // datapath
    t_addr                      r_cur_wp;
    t_sample                    r_dry;
    logic [PHASE_BITS-1:0]      r_p;
    logic [SINE_BITS-1:0]       r_sabs;
    logic                       r_sneg;
    logic [PROD1_BITS-1:0]      r_prod1;
    logic [MAG_BITS-1:0]        r_mag;
    logic [DLY_BITS-1:0]        r_delay;
    logic signed [WA_BITS-1:0]  r_wet_acc;
    t_sample                    r_wet;
    logic signed [MA_BITS-1:0]  r_mix_acc;
    logic                       r_out_valid;
    t_sample                    r_out;

    logic                       accept;
    logic                       out_free;
    logic [MIXW_BITS-1:0]       det;
    logic [MIXW_BITS-1:0]       mix;
    logic [MIXW_BITS:0]         mix_dry;
    logic [1:0]                 quad;
    logic [SINE_IDX_BITS-1:0]   sidx;
    logic [SINE_IDX_BITS:0]     tidx;
    logic [PROD2_BITS-1:0]      prod2;
    logic signed [DSUM_BITS-1:0] dsum;
    logic [DLY_BITS-1:0]        dclamp;
    logic [DLY_BITS-1:0]        pos;
    t_addr                      i0;
    t_addr                      i1;
    logic [FRAC_BITS-1:0]       frac;
    logic [FRAC_BITS:0]         w0;
    t_sample                    rd_data;
    logic                       rd_en;
    t_addr                      rd_addr;
    logic signed [WA_BITS-1:0]  wet_p0;
    logic signed [WA_BITS-1:0]  wet_p1;
    logic signed [WA_BITS-1:0]  wet_sum;
    logic signed [MA_BITS-1:0]  mix_p0;
    logic signed [MA_BITS-1:0]  mix_p1;
    logic signed [MA_BITS-1:0]  mix_sum;
    logic signed [RES_BITS-1:0] res;
    t_sample                    res_sat;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_sample_out = r_out;
    assign o_cfg_ready = 1'b1;

    // detune and mix saturate at one
    assign det = (r_detune > MIXW_BITS'(Q15_ONE)) ? MIXW_BITS'(Q15_ONE) : r_detune;
    assign mix = (r_wet_mix > MIXW_BITS'(Q15_ONE)) ? MIXW_BITS'(Q15_ONE) : r_wet_mix;
    assign mix_dry = (MIXW_BITS+1)'(Q15_ONE) - {1'b0, mix};

    // quadrant fold of the quarter-wave table
    assign quad = r_p[PHASE_BITS-1 -: 2];
    assign sidx = r_p[PHASE_BITS-3 -: SINE_IDX_BITS];
    assign tidx = quad[0] ? ((SINE_IDX_BITS+1)'(SINE_TABLE_DEPTH) - {1'b0, sidx})
                          : {1'b0, sidx};

    assign prod2 = PROD2_BITS'(r_prod1) * PROD2_BITS'(det);

    always_comb begin
        if (r_sneg) begin
            dsum = DSUM_BITS'(signed'({1'b0, r_center})) - DSUM_BITS'(signed'({1'b0, r_mag}));
        end else begin
            dsum = DSUM_BITS'(signed'({1'b0, r_center})) + DSUM_BITS'(signed'({1'b0, r_mag}));
        end
        if (dsum < 0) begin
            dclamp = '0;
        end else if (dsum > DSUM_BITS'(MAX_DELAY)) begin
            dclamp = DLY_BITS'(MAX_DELAY);
        end else begin
            dclamp = dsum[DLY_BITS-1:0];
        end
    end

    // read position behind the write pointer, wraps over the whole memory
    assign pos  = {r_cur_wp, {FRAC_BITS{1'b0}}} - r_delay;
    assign i0   = pos[DLY_BITS-1:FRAC_BITS];
    assign frac = pos[FRAC_BITS-1:0];
    assign i1   = i0 + 1'b1;
    assign w0   = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac};

    assign rd_en   = (r_state == S_RD0) || (r_state == S_RD1);
    assign rd_addr = (r_state == S_RD0) ? i0 : i1;

    assign wet_p0  = WA_BITS'(rd_data) * WA_BITS'(signed'({1'b0, w0}));
    assign wet_p1  = WA_BITS'(rd_data) * WA_BITS'(signed'({1'b0, frac}));
    assign wet_sum = r_wet_acc + WA_BITS'(1 << (FRAC_BITS - 1));

    assign mix_p0  = MA_BITS'(r_dry) * MA_BITS'(signed'({1'b0, mix_dry}));
    assign mix_p1  = MA_BITS'(r_wet) * MA_BITS'(signed'({1'b0, mix}));
    assign mix_sum = r_mix_acc + MA_BITS'(1 << (Q15_BITS - 1));
    assign res     = mix_sum[MA_BITS-1:Q15_BITS];

    always_comb begin
        if (res > RES_MAX) begin
            res_sat = RES_MAX[SAMPLE_BITS-1:0];
        end else if (res < RES_MIN) begin
            res_sat = RES_MIN[SAMPLE_BITS-1:0];
        end else begin
            res_sat = res[SAMPLE_BITS-1:0];
        end
    end

    lmdd_delay_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (accept),
        .i_wr_addr  (r_wp),
        .i_wr_data  (i_sample_in),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lfo_phase <= '0;
            r_wp        <= '0;
            r_phase_inc <= PHASE_BITS'(7);
            r_phase_off <= '0;
            r_detune    <= MIXW_BITS'(16384);
            r_wet_mix   <= MIXW_BITS'(16384);
            r_center    <= CENTER_BITS'(153600);
            r_max_depth <= DEPTH_BITS'(76800);
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_PHASE_INC: r_phase_inc <= i_cfg_data[PHASE_BITS-1:0];
                    REG_PHASE_OFF: r_phase_off <= i_cfg_data[PHASE_BITS-1:0];
                    REG_DETUNE:    r_detune    <= i_cfg_data[MIXW_BITS-1:0];
                    REG_WET_MIX:   r_wet_mix   <= i_cfg_data[MIXW_BITS-1:0];
                    REG_CENTER:    r_center    <= i_cfg_data[CENTER_BITS-1:0];
                    REG_MAX_DEPTH: r_max_depth <= i_cfg_data[DEPTH_BITS-1:0];
                    default: ;
                endcase
            end

            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_dry       <= i_sample_in;
                        r_cur_wp    <= r_wp;
                        r_wp        <= r_wp + 1'b1;
                        r_p         <= r_lfo_phase + r_phase_off;
                        r_lfo_phase <= r_lfo_phase + r_phase_inc;
                        r_state     <= S_SINE;
                    end
                end
                S_SINE: begin
                    r_sabs  <= SINE_TBL[tidx];
                    r_sneg  <= quad[1];
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_prod1 <= PROD1_BITS'(r_sabs) * PROD1_BITS'(r_max_depth);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_mag   <= prod2[PROD2_BITS-1:30];
                    r_state <= S_DELAY;
                end
                S_DELAY: begin
                    r_delay <= dclamp;
                    r_state <= S_RD0;
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_wet_acc <= wet_p0;
                    r_state   <= S_WET;
                end
                S_WET: begin
                    r_wet_acc <= r_wet_acc + wet_p1;
                    r_state   <= S_MIX0;
                end
                S_MIX0: begin
                    r_wet     <= wet_sum[FRAC_BITS +: SAMPLE_BITS];
                    r_mix_acc <= mix_p0;
                    r_state   <= S_MIX1;
                end
                S_MIX1: begin
                    r_mix_acc <= r_mix_acc + mix_p1;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out       <= res_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
